// ----- rtl/core/owtr_pkg.sv -----
// Shared types, constants and command table for the one-wire temperature reader.
`timescale 1ns / 1ps
`default_nettype none

package owtr_pkg;

   localparam int TIMER_BITS_DEF = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RESET_LOW    = 3'd0,
      CSR_PRES_POLL    = 3'd1,
      CSR_PRES_RETRIES = 3'd2,
      CSR_WRITE_SLOT   = 3'd3,
      CSR_READ_SAMPLE  = 3'd4,
      CSR_READ_RECOVER = 3'd5,
      CSR_GAP          = 3'd6
   } csr_addr_type;

   localparam logic [15:0] RESET_LOW_DEF    = 16'd800;
   localparam logic [15:0] PRES_POLL_DEF    = 16'd1000;
   localparam logic [3:0]  PRES_RETRIES_DEF = 4'd5;
   localparam logic [15:0] WRITE_SLOT_DEF   = 16'd70;
   localparam logic [7:0]  READ_SAMPLE_DEF  = 8'd5;
   localparam logic [15:0] READ_RECOVER_DEF = 16'd50;
   localparam logic [15:0] GAP_DEF          = 16'd10;

   localparam logic [7:0] CMD_SKIP_ROM   = 8'hcc;
   localparam logic [7:0] CMD_CONVERT    = 8'h44;
   localparam logic [7:0] CMD_READ_SCRPD = 8'hbe;

   typedef struct packed {
      logic [15:0] reset_low_ticks;
      logic [15:0] presence_poll_ticks;
      logic [3:0]  presence_retries;
      logic [15:0] write_slot_ticks;
      logic [7:0]  read_sample_ticks;
      logic [15:0] read_recover_ticks;
      logic [15:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic        pull_low;
      logic        busy_res;
      logic        done_res;
      logic        failed;
      logic [15:0] raw_reading;
   } seq_res_type;

   function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = CMD_SKIP_ROM;
         2'd1:    b = CMD_CONVERT;
         2'd2:    b = CMD_SKIP_ROM;
         default: b = CMD_READ_SCRPD;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/owtr_centi.sv -----
// Converts a signed raw reading (1/16 degree) to hundredths of a degree, rounded.
`timescale 1ns / 1ps
`default_nettype none

module owtr_centi (
   input  wire logic signed [15:0] raw_reading,
   output logic signed [18:0]      centi_degrees
);
   logic        neg;
   logic [16:0] mag;
   logic [19:0] prod;
   logic [18:0] c_mag;

   // |raw| * 6.25 = (|raw| * 25 + 2) >> 2, half away from zero
   always_comb begin
      neg   = raw_reading[15];
      mag   = neg ? (17'h10000 - {1'b0, raw_reading}) : {1'b0, raw_reading};
      prod  = (20'(mag) << 4) + (20'(mag) << 3) + 20'(mag) + 20'd2;
      c_mag = {1'b0, prod[19:2]};
      centi_degrees = neg ? (~c_mag + 19'd1) : c_mag;
   end

endmodule

`default_nettype wire

// ----- rtl/core/owtr_seq.sv -----
// One-wire bus sequencer: reset/presence, command writes, scratchpad reads, one tick per step.
`timescale 1ns / 1ps
`default_nettype none

module owtr_seq #(
   parameter int TIMER_BITS = owtr_pkg::TIMER_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic                 start_req,
   input  wire logic                 bus_level,
   input  wire owtr_pkg::cfg_type     cfg,
   output owtr_pkg::seq_res_type      res
);
   import owtr_pkg::*;

   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   typedef enum logic [11:0] {
      PH_IDLE        = 12'b0000_0000_0001,
      PH_RST_LOW     = 12'b0000_0000_0010,
      PH_PRES_SAMPLE = 12'b0000_0000_0100,
      PH_PRES_POLL   = 12'b0000_0000_1000,
      PH_GAP_PRES    = 12'b0000_0001_0000,
      PH_WR_START    = 12'b0000_0010_0000,
      PH_WR_HOLD     = 12'b0000_0100_0000,
      PH_WR_REC      = 12'b0000_1000_0000,
      PH_GAP_BYTE    = 12'b0001_0000_0000,
      PH_RD_START    = 12'b0010_0000_0000,
      PH_RD_SAMPLE   = 12'b0100_0000_0000,
      PH_RD_REC      = 12'b1000_0000_0000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [3:0]            retry_ff, retry_in;
   logic [2:0]            bit_ff, bit_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            first_ff, first_in;
   logic [15:0]           reading_ff, reading_in;

   logic [15:0]           lim;
   logic [TIMER_BITS-1:0] t_inc;
   logic                  elapsed;
   logic                  done, fail;

   // one shared timer; the limit follows the phase
   always_comb begin
      unique case (phase_ff)
         PH_RST_LOW:   lim = cfg.reset_low_ticks;
         PH_PRES_POLL: lim = cfg.presence_poll_ticks;
         PH_GAP_PRES,
         PH_GAP_BYTE:  lim = cfg.gap_ticks;
         PH_WR_HOLD:   lim = cfg.write_slot_ticks;
         PH_RD_SAMPLE: lim = {8'd0, cfg.read_sample_ticks};
         PH_RD_REC:    lim = cfg.read_recover_ticks;
         default:      lim = 16'd1;
      endcase
      t_inc   = (timer_ff != TMAX) ? timer_ff + TIMER_BITS'(1) : timer_ff;
      elapsed = (CW'(t_inc) >= CW'(lim)) || (t_inc == TMAX);
   end

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      retry_in   = retry_ff;
      bit_in     = bit_ff;
      cmd_in     = cmd_ff;
      shift_in   = shift_ff;
      first_in   = first_ff;
      reading_in = reading_ff;
      done       = 1'b0;
      fail       = 1'b0;

      unique case (phase_ff)
         PH_RST_LOW: begin
            timer_in = elapsed ? '0 : t_inc;
            if (elapsed) begin
               retry_in = 4'd0;
               phase_in = PH_PRES_SAMPLE;
            end
         end
         PH_PRES_SAMPLE: begin
            timer_in = '0;
            phase_in = bus_level ? PH_PRES_POLL : PH_GAP_PRES;
         end
         PH_PRES_POLL: begin
            timer_in = elapsed ? '0 : t_inc;
            if (elapsed) begin
               if (retry_ff >= cfg.presence_retries) begin
                  done     = 1'b1;
                  fail     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  retry_in = retry_ff + 4'd1;
                  phase_in = PH_PRES_SAMPLE;
               end
            end
         end
         PH_GAP_PRES: begin
            timer_in = elapsed ? '0 : t_inc;
            if (elapsed) begin
               shift_in = cmd_byte(cmd_ff[1:0]);
               bit_in   = 3'd0;
               phase_in = PH_WR_START;
            end
         end
         PH_WR_START: begin
            timer_in = '0;
            phase_in = PH_WR_HOLD;
         end
         PH_WR_HOLD: begin
            timer_in = elapsed ? '0 : t_inc;
            if (elapsed) begin
               phase_in = PH_WR_REC;
            end
         end
         PH_WR_REC: begin
            timer_in = '0;
            shift_in = {1'b0, shift_ff[7:1]};
            if (bit_ff == 3'd7) begin
               bit_in   = 3'd0;
               phase_in = PH_GAP_BYTE;
            end else begin
               bit_in   = bit_ff + 3'd1;
               phase_in = PH_WR_START;
            end
         end
         PH_GAP_BYTE: begin
            timer_in = elapsed ? '0 : t_inc;
            if (elapsed) begin
               if (cmd_ff == 3'd1) begin
                  cmd_in   = 3'd2;
                  phase_in = PH_RST_LOW;
               end else if (cmd_ff >= 3'd3) begin
                  cmd_in   = 3'd4;
                  shift_in = 8'd0;
                  bit_in   = 3'd0;
                  phase_in = PH_RD_START;
               end else begin
                  cmd_in   = cmd_ff + 3'd1;
                  shift_in = cmd_byte(cmd_in[1:0]);
                  bit_in   = 3'd0;
                  phase_in = PH_WR_START;
               end
            end
         end
         PH_RD_START: begin
            timer_in = '0;
            phase_in = PH_RD_SAMPLE;
         end
         PH_RD_SAMPLE: begin
            timer_in = elapsed ? '0 : t_inc;
            if (elapsed) begin
               shift_in = {bus_level, shift_ff[7:1]};
               phase_in = PH_RD_REC;
            end
         end
         PH_RD_REC: begin
            timer_in = elapsed ? '0 : t_inc;
            if (elapsed) begin
               if (bit_ff != 3'd7) begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_RD_START;
               end else if (cmd_ff == 3'd4) begin
                  first_in = shift_ff;
                  cmd_in   = 3'd5;
                  shift_in = 8'd0;
                  bit_in   = 3'd0;
                  phase_in = PH_RD_START;
               end else begin
                  reading_in = {shift_ff, first_ff};
                  bit_in     = 3'd0;
                  cmd_in     = 3'd0;
                  done       = 1'b1;
                  phase_in   = PH_IDLE;
               end
            end
         end
         default: begin
            // idle, and any stray code
            phase_in = PH_IDLE;
            if (start_req) begin
               cmd_in   = 3'd0;
               retry_in = 4'd0;
               bit_in   = 3'd0;
               timer_in = '0;
               phase_in = PH_RST_LOW;
            end
         end
      endcase
   end

   always_comb begin
      unique case (phase_in)
         PH_RST_LOW,
         PH_WR_START,
         PH_RD_START: res.pull_low = 1'b1;
         PH_WR_HOLD:  res.pull_low = ~shift_in[0];
         default:     res.pull_low = 1'b0;
      endcase
      res.busy_res    = (phase_in != PH_IDLE);
      res.done_res    = done;
      res.failed      = fail;
      res.raw_reading = reading_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         retry_ff   <= 4'd0;
         bit_ff     <= 3'd0;
         cmd_ff     <= 3'd0;
         shift_ff   <= 8'd0;
         first_ff   <= 8'd0;
         reading_ff <= 16'd0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         retry_ff   <= retry_in;
         bit_ff     <= bit_in;
         cmd_ff     <= cmd_in;
         shift_ff   <= shift_in;
         first_ff   <= first_in;
         reading_ff <= reading_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/one_wire_temperature_reader.sv -----
// Top level of the one-wire temperature reader: config registers, sequencer, result register.
//
// Usage: each req transaction is one microsecond tick of the one-wire bus and
// carries start_req and the sampled bus level; each tick yields exactly one rsp
// transaction with the drive for the line (pull_low), busy, a one-tick done,
// the failure flag (no presence pulse) and the last good reading, raw and in
// hundredths of a degree. A start is taken only while idle.
// The rsp is registered and appears in the cycle after its req is accepted; one tick
// is accepted per cycle unless the receiver stalls, since the whole step of the
// sequencer sits between its state and the rsp register. req_tready is high while
// the rsp register is empty or being emptied, so a stalled receiver holds the
// current result and stops tick intake. Timing registers must be written through
// csr_* only while no tick is in flight; the block does not enforce this. A write
// to an index past the list is ignored. Synchronous reset puts the sequencer in
// idle, clears the stored reading and loads default timings (800/1000/5/70/5/50/10 ticks).
`timescale 1ns / 1ps
`default_nettype none

module one_wire_temperature_reader #(
   parameter int TIMER_BITS = owtr_pkg::TIMER_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [0] start_req, [1] bus_level, [7:2] zero
   input  wire logic [owtr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] pull_low, [1] busy_res, [2] done_res, [3] failed,
   // [19:4] raw_reading, [38:20] centi_degrees, [39] zero
   output logic [owtr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_wen,
   input  wire logic [owtr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [owtr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import owtr_pkg::*;

   cfg_type                 cfg_ff;
   seq_res_type             res;
   logic signed [18:0]      centi;
   logic                    req_fire;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RESET_LOW_DEF;
         cfg_ff.presence_poll_ticks <= PRES_POLL_DEF;
         cfg_ff.presence_retries    <= PRES_RETRIES_DEF;
         cfg_ff.write_slot_ticks    <= WRITE_SLOT_DEF;
         cfg_ff.read_sample_ticks   <= READ_SAMPLE_DEF;
         cfg_ff.read_recover_ticks  <= READ_RECOVER_DEF;
         cfg_ff.gap_ticks           <= GAP_DEF;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_RESET_LOW:    cfg_ff.reset_low_ticks     <= csr_wdata;
            CSR_PRES_POLL:    cfg_ff.presence_poll_ticks <= csr_wdata;
            CSR_PRES_RETRIES: cfg_ff.presence_retries    <= csr_wdata[3:0];
            CSR_WRITE_SLOT:   cfg_ff.write_slot_ticks    <= csr_wdata;
            CSR_READ_SAMPLE:  cfg_ff.read_sample_ticks   <= csr_wdata[7:0];
            CSR_READ_RECOVER: cfg_ff.read_recover_ticks  <= csr_wdata;
            CSR_GAP:          cfg_ff.gap_ticks           <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;

   owtr_seq #(
      .TIMER_BITS(TIMER_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_fire),
      .start_req (req_tdata[0]),
      .bus_level (req_tdata[1]),
      .cfg       (cfg_ff),
      .res       (res)
   );

   owtr_centi u_centi (
      .raw_reading   (res.raw_reading),
      .centi_degrees (centi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {1'b0, centi, res.raw_reading, res.failed, res.done_res,
                         res.busy_res, res.pull_low};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fail_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2])
      else $error("failed without done");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("done while still busy");

   a_centi_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[38] == rsp_tdata[19]))
      else $error("centi_degrees sign differs from raw_reading");

endmodule

`default_nettype wire

// ----- tb/one_wire_temperature_reader_tb.sv -----
// Testbench for the one-wire temperature reader: streams bus ticks, predicts each result, compares.
`timescale 1ns / 1ps

module one_wire_temperature_reader_tb;
   import owtr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam logic [2:0]  CSR_UNMAPPED = 3'd7;
   localparam logic [15:0] TMAX = 16'hffff;

   typedef enum logic [4:0] {
      PH_IDLE, PH_RST_LOW, PH_PRES_SAMPLE, PH_PRES_POLL, PH_GAP_PRES, PH_WR_START,
      PH_WR_HOLD, PH_WR_REC, PH_GAP_BYTE, PH_RD_START, PH_RD_SAMPLE, PH_RD_REC
   } bus_phase_type;

   typedef struct packed {
      bus_phase_type phase;
      logic [15:0]   timer;
      logic [3:0]    retries;
      logic [2:0]    bit_idx;
      logic [2:0]    cmd_idx;
      logic [7:0]    shreg;
      logic [7:0]    lo_byte;
      logic [15:0]   reading;
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic level;
   } tick_type;

   typedef struct packed {
      logic        pull;
      logic        busy;
      logic        done;
      logic        fail;
      logic [15:0] raw;
      logic [18:0] centi;
   } tick_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfg_type cfg_m = '{RESET_LOW_DEF, PRES_POLL_DEF, PRES_RETRIES_DEF, WRITE_SLOT_DEF,
                      READ_SAMPLE_DEF, READ_RECOVER_DEF, GAP_DEF};
   seq_state_type gen_st = '0;
   seq_state_type chk_st = '0;
   tick_type tick_q[$];
   tick_out_type tick_out_q[$];
   int unsigned ticks_made = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   bit idle_on = 1'b1;

   one_wire_temperature_reader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned pick_pause(input bit on);
      int unsigned r;
      r = $urandom_range(99);
      if (!on || r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // {elapsed, next timer}; saturates at TMAX and always takes at least one tick
   function automatic logic [16:0] timer_adv(input logic [15:0] t, input logic [15:0] lim);
      logic [15:0] nt;
      nt = (t != TMAX) ? t + 16'd1 : t;
      if (nt >= lim || nt == TMAX) return {1'b1, 16'd0};
      return {1'b0, nt};
   endfunction

   function automatic logic [7:0] command_at(input logic [2:0] idx);
      case (idx[1:0])
         2'd0:    return CMD_SKIP_ROM;
         2'd1:    return CMD_CONVERT;
         2'd2:    return CMD_SKIP_ROM;
         default: return CMD_READ_SCRPD;
      endcase
   endfunction

   function automatic logic [18:0] centi_of(input logic [15:0] raw);
      logic [16:0] mag;
      logic [21:0] c;
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      c = ({5'd0, mag} * 22'd25 + 22'd2) >> 2;
      return raw[15] ? (19'd0 - c[18:0]) : c[18:0];
   endfunction

   function automatic void master_step(input seq_state_type s, input logic start,
                                       input logic level, output seq_state_type n,
                                       output tick_out_type o);
      logic [16:0] adv;
      logic done, fail;
      n = s;
      done = 1'b0;
      fail = 1'b0;
      case (s.phase)
         PH_RST_LOW: begin
            adv = timer_adv(s.timer, cfg_m.reset_low_ticks);
            n.timer = adv[15:0];
            if (adv[16]) begin
               n.retries = '0;
               n.phase = PH_PRES_SAMPLE;
            end
         end
         PH_PRES_SAMPLE: begin
            n.phase = level ? PH_PRES_POLL : PH_GAP_PRES;
            n.timer = '0;
         end
         PH_PRES_POLL: begin
            adv = timer_adv(s.timer, cfg_m.presence_poll_ticks);
            n.timer = adv[15:0];
            if (adv[16]) begin
               if (s.retries >= cfg_m.presence_retries) begin
                  done = 1'b1;
                  fail = 1'b1;
                  n.phase = PH_IDLE;
               end else begin
                  n.retries = s.retries + 4'd1;
                  n.phase = PH_PRES_SAMPLE;
               end
            end
         end
         PH_GAP_PRES: begin
            adv = timer_adv(s.timer, cfg_m.gap_ticks);
            n.timer = adv[15:0];
            if (adv[16]) begin
               n.shreg = command_at(s.cmd_idx);
               n.bit_idx = '0;
               n.phase = PH_WR_START;
            end
         end
         PH_WR_START: begin
            n.phase = PH_WR_HOLD;
            n.timer = '0;
         end
         PH_WR_HOLD: begin
            adv = timer_adv(s.timer, cfg_m.write_slot_ticks);
            n.timer = adv[15:0];
            if (adv[16]) n.phase = PH_WR_REC;
         end
         PH_WR_REC: begin
            n.shreg = s.shreg >> 1;
            n.timer = '0;
            if (s.bit_idx == 3'd7) begin
               n.bit_idx = '0;
               n.phase = PH_GAP_BYTE;
            end else begin
               n.bit_idx = s.bit_idx + 3'd1;
               n.phase = PH_WR_START;
            end
         end
         PH_GAP_BYTE: begin
            adv = timer_adv(s.timer, cfg_m.gap_ticks);
            n.timer = adv[15:0];
            if (adv[16]) begin
               if (s.cmd_idx == 3'd1) begin
                  n.cmd_idx = 3'd2;
                  n.phase = PH_RST_LOW;
               end else if (s.cmd_idx >= 3'd3) begin
                  n.cmd_idx = 3'd4;
                  n.shreg = '0;
                  n.bit_idx = '0;
                  n.phase = PH_RD_START;
               end else begin
                  n.cmd_idx = s.cmd_idx + 3'd1;
                  n.shreg = command_at(s.cmd_idx + 3'd1);
                  n.bit_idx = '0;
                  n.phase = PH_WR_START;
               end
            end
         end
         PH_RD_START: begin
            n.phase = PH_RD_SAMPLE;
            n.timer = '0;
         end
         PH_RD_SAMPLE: begin
            adv = timer_adv(s.timer, {8'd0, cfg_m.read_sample_ticks});
            n.timer = adv[15:0];
            if (adv[16]) begin
               n.shreg = {level, s.shreg[7:1]};
               n.phase = PH_RD_REC;
            end
         end
         PH_RD_REC: begin
            adv = timer_adv(s.timer, cfg_m.read_recover_ticks);
            n.timer = adv[15:0];
            if (adv[16]) begin
               if (s.bit_idx != 3'd7) begin
                  n.bit_idx = s.bit_idx + 3'd1;
                  n.phase = PH_RD_START;
               end else if (s.cmd_idx == 3'd4) begin
                  n.lo_byte = s.shreg;
                  n.cmd_idx = 3'd5;
                  n.shreg = '0;
                  n.bit_idx = '0;
                  n.phase = PH_RD_START;
               end else begin
                  n.reading = {s.shreg, s.lo_byte};
                  n.bit_idx = '0;
                  n.cmd_idx = '0;
                  done = 1'b1;
                  n.phase = PH_IDLE;
               end
            end
         end
         default: begin
            n.phase = PH_IDLE;
            if (start) begin
               n.cmd_idx = '0;
               n.retries = '0;
               n.bit_idx = '0;
               n.timer = '0;
               n.phase = PH_RST_LOW;
            end
         end
      endcase
      case (n.phase)
         PH_RST_LOW, PH_WR_START, PH_RD_START: o.pull = 1'b1;
         PH_WR_HOLD: o.pull = ~n.shreg[0];
         default:    o.pull = 1'b0;
      endcase
      o.busy = (n.phase != PH_IDLE);
      o.done = done;
      o.fail = fail;
      o.raw = n.reading;
      o.centi = centi_of(n.reading);
   endfunction

   // driver: one tick per transaction, random gaps between them
   always @(posedge clock) begin : driver
      tick_type nxt;
      tick_out_type o;
      seq_state_type ns;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            master_step(chk_st, req_tdata[0], req_tdata[1], ns, o);
            chk_st = ns;
            tick_out_q.push_back(o);
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait != 0) begin
               req_tvalid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (tick_q.size() != 0) begin
               nxt = tick_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, nxt.level, nxt.start};
               send_wait <= pick_pause(idle_on);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      tick_out_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.pull = rsp_tdata[0];
            got.busy = rsp_tdata[1];
            got.done = rsp_tdata[2];
            got.fail = rsp_tdata[3];
            got.raw = rsp_tdata[19:4];
            got.centi = rsp_tdata[38:20];
            if (tick_out_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected transaction, data %h", $time, rsp_tdata);
            end else begin
               want = tick_out_q.pop_front();
               if (got.pull !== want.pull || got.busy !== want.busy ||
                   got.done !== want.done || got.fail !== want.fail ||
                   got.raw !== want.raw || got.centi !== want.centi) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: pull/busy/done/fail/raw/centi exp %b %b %b %b %0d %0d got %b %b %b %b %0d %0d",
                              $time, want.pull, want.busy, want.done, want.fail,
                              $signed(want.raw), $signed(want.centi), got.pull, got.busy,
                              got.done, got.fail, $signed(got.raw), $signed(got.centi));
               end
            end
         end
         if (recv_wait != 0) begin
            rsp_tready <= 1'b0;
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_wait <= pick_pause(idle_on);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("one_wire_temperature_reader: mismatch");
         $finish;
      end
   end

   task automatic push_tick(input logic start, input logic level);
      seq_state_type ns;
      tick_out_type o;
      tick_type t;
      master_step(gen_st, start, level, ns, o);
      gen_st = ns;
      t.start = start;
      t.level = level;
      tick_q.push_back(t);
      ticks_made++;
   endtask

   // n ticks with random starts, then quiet ticks until the sequence ends
   task automatic gen_run(input int unsigned n, input int unsigned start_pct,
                          input int unsigned present_pct);
      int unsigned k;
      logic lv;
      for (k = 0; k < n || gen_st.phase != PH_IDLE; k++) begin
         if (gen_st.phase == PH_PRES_SAMPLE) lv = ($urandom_range(99) >= present_pct);
         else lv = ($urandom_range(1) != 0);
         push_tick(k < n && $urandom_range(99) < start_pct, lv);
      end
   endtask

   task automatic wait_idle;
      while (results_seen != ticks_made) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] a, input logic [15:0] v);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (a)
         CSR_RESET_LOW:    cfg_m.reset_low_ticks = v;
         CSR_PRES_POLL:    cfg_m.presence_poll_ticks = v;
         CSR_PRES_RETRIES: cfg_m.presence_retries = v[3:0];
         CSR_WRITE_SLOT:   cfg_m.write_slot_ticks = v;
         CSR_READ_SAMPLE:  cfg_m.read_sample_ticks = v[7:0];
         CSR_READ_RECOVER: cfg_m.read_recover_ticks = v;
         CSR_GAP:          cfg_m.gap_ticks = v;
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic [15:0] rl, pp, pr, ws, rs, rr, gp,
                            input int unsigned n, start_pct, present_pct, input bit idle);
      wait_idle();
      csr_write(CSR_RESET_LOW, rl);
      csr_write(CSR_PRES_POLL, pp);
      csr_write(CSR_PRES_RETRIES, pr);
      csr_write(CSR_WRITE_SLOT, ws);
      csr_write(CSR_READ_SAMPLE, rs);
      csr_write(CSR_READ_RECOVER, rr);
      csr_write(CSR_GAP, gp);
      csr_write(CSR_UNMAPPED, 16'($urandom));
      idle_on = idle;
      @(negedge clock);
      gen_run(n, start_pct, present_pct);
   endtask

   initial begin : stimulus
      int unsigned k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // reset timings; starts while busy must be ignored
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b1);
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b0);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);
      // still inside the default reset pulse; short timings take over mid-pulse
      for (k = 0; k < 13; k++)
         push_tick(1'b0, 1'($urandom_range(1)));
      run_phase(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 80, 25, 70, 1'b1);
      // zero timings; upper bits beyond the register width dropped
      run_phase(16'd0, 16'd0, 16'hfff0, 16'd0, 16'hff00, 16'd0, 16'd0, 60, 25, 70, 1'b1);
      run_phase(16'($urandom_range(2, 1)), 16'($urandom_range(2, 1)),
                16'($urandom_range(15, 0)), 16'($urandom_range(2, 1)),
                16'($urandom_range(2, 1)), 16'($urandom_range(2, 1)),
                16'($urandom_range(2, 1)), 40, 20, 70, 1'b1);
      run_phase(16'd1, 16'd2, 16'd15, 16'd1, 16'h1201, 16'd1, 16'd1, 60, 30, 10, 1'b1);
      // no gaps on either side
      run_phase(16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 40, 100, 50, 1'b0);
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && tick_out_q.size() == 0)
         $display("one_wire_temperature_reader: match");
      else
         $display("one_wire_temperature_reader: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/owtr_pkg.sv
rtl/core/owtr_centi.sv
rtl/core/owtr_seq.sv
rtl/core/one_wire_temperature_reader.sv
tb/one_wire_temperature_reader_tb.sv
